FILE: sv/hsvd_pkg.sv
// ----------------------------------------------------------------------------
// hsvd_pkg
// Shared types and constants for the dimmed HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvd_pkg;

  // channel width and hue split
  localparam int unsigned ChanW   = 8;
  localparam int unsigned OffsetW = 6;

  // power limit after reset
  localparam logic [ChanW-1:0] PowerLimitReset = 8'd32;

  // hue section codes
  typedef enum logic [1:0] {
    SECT_0 = 2'd0,
    SECT_1 = 2'd1,
    SECT_2 = 2'd2
  } sect_e;

  // one color triplet
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // truncating scale: (x * s) >> 8
  function automatic logic [ChanW-1:0] scale8(input logic [ChanW-1:0] x,
                                              input logic [ChanW-1:0] s);
    logic [2*ChanW-1:0] prod;
    prod = x * s;
    return prod[2*ChanW-1:ChanW];
  endfunction

endpackage

FILE: sv/hsvd_color.sv
// ----------------------------------------------------------------------------
// hsvd_color
// Two pipeline stages: floor and amplitude, then ramps and section mapping.
// ----------------------------------------------------------------------------
module hsvd_color import hsvd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ChanW-1:0] hue_i,
  input  logic [ChanW-1:0] saturation_i,
  input  logic [ChanW-1:0] value_level_i,
  input  logic [ChanW-1:0] dim_level_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rgb_t             rgb_o,
  output logic [ChanW-1:0] dim_o
);

  // stage a registers
  logic               a_valid_q;
  logic [ChanW-1:0]   a_floor_q, a_floor_d;
  logic [ChanW-1:0]   a_amp_q, a_amp_d;
  logic [OffsetW-1:0] a_offset_q;
  sect_e              a_sect_q, a_sect_d;
  logic [ChanW-1:0]   a_dim_q;
  logic               a_ready;

  // stage b registers
  logic               b_valid_q;
  rgb_t               b_rgb_q, b_rgb_d;
  logic [ChanW-1:0]   b_dim_q;
  logic               b_ready;

  logic [ChanW-1:0]         inv_sat;
  logic [2*ChanW-1:0]       floor_prod;
  logic [OffsetW-1:0]       fall_off;
  logic [OffsetW+ChanW-1:0] rise_prod;
  logic [OffsetW+ChanW-1:0] fall_prod;
  logic [ChanW-1:0]         rise;
  logic [ChanW-1:0]         fall;

  // stall chain: a stage takes a beat when empty or draining
  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // floor = value * (255 - sat) >> 8, amplitude = value - floor
  always_comb begin
    inv_sat    = ~saturation_i;
    floor_prod = value_level_i * inv_sat;
    a_floor_d  = floor_prod[2*ChanW-1:ChanW];
    a_amp_d    = value_level_i - a_floor_d;
    case (hue_i[ChanW-1:OffsetW])
      2'd0:    a_sect_d = SECT_0;
      2'd1:    a_sect_d = SECT_1;
      default: a_sect_d = SECT_2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_floor_q  <= a_floor_d;
      a_amp_q    <= a_amp_d;
      a_offset_q <= hue_i[OffsetW-1:0];
      a_sect_q   <= a_sect_d;
      a_dim_q    <= dim_level_i;
    end
  end

  // rising and falling ramps on top of the floor
  always_comb begin
    fall_off  = ~a_offset_q;
    rise_prod = a_offset_q * a_amp_q;
    fall_prod = fall_off * a_amp_q;
    rise      = a_floor_q + rise_prod[OffsetW+ChanW-1:OffsetW];
    fall      = a_floor_q + fall_prod[OffsetW+ChanW-1:OffsetW];
    case (a_sect_q)
      SECT_0: begin
        b_rgb_d.red   = fall;
        b_rgb_d.green = rise;
        b_rgb_d.blue  = a_floor_q;
      end
      SECT_1: begin
        b_rgb_d.red   = a_floor_q;
        b_rgb_d.green = fall;
        b_rgb_d.blue  = rise;
      end
      default: begin
        b_rgb_d.red   = rise;
        b_rgb_d.green = a_floor_q;
        b_rgb_d.blue  = fall;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_rgb_q <= b_rgb_d;
      b_dim_q <= a_dim_q;
    end
  end

  assign out_valid_o = b_valid_q;
  assign rgb_o       = b_rgb_q;
  assign dim_o       = b_dim_q;

endmodule

FILE: sv/hsvd_scale.sv
// ----------------------------------------------------------------------------
// hsvd_scale
// Two pipeline stages: per-beat dim scaling, then global power scaling.
// ----------------------------------------------------------------------------
module hsvd_scale import hsvd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rgb_t             rgb_i,
  input  logic [ChanW-1:0] dim_i,
  input  logic [ChanW-1:0] power_limit_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rgb_t             rgb_o
);

  logic c_valid_q;
  rgb_t c_rgb_q, c_rgb_d;
  logic c_ready;

  logic d_valid_q;
  rgb_t d_rgb_q, d_rgb_d;
  logic d_ready;

  // stall chain, last stage is the output register
  assign d_ready    = !d_valid_q || out_ready_i;
  assign c_ready    = !c_valid_q || d_ready;
  assign in_ready_o = c_ready;

  // dim scaling
  always_comb begin
    c_rgb_d.red   = scale8(rgb_i.red,   dim_i);
    c_rgb_d.green = scale8(rgb_i.green, dim_i);
    c_rgb_d.blue  = scale8(rgb_i.blue,  dim_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      c_rgb_q <= c_rgb_d;
    end
  end

  // power limit scaling
  always_comb begin
    d_rgb_d.red   = scale8(c_rgb_q.red,   power_limit_i);
    d_rgb_d.green = scale8(c_rgb_q.green, power_limit_i);
    d_rgb_d.blue  = scale8(c_rgb_q.blue,  power_limit_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (d_ready) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready && c_valid_q) begin
      d_rgb_q <= d_rgb_d;
    end
  end

  assign out_valid_o = d_valid_q;
  assign rgb_o       = d_rgb_q;

endmodule

FILE: sv/hsv_to_rgb_dimmed_core.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_dimmed_core
// HSV to RGB conversion with per-beat dimming and a global power limit.
// ----------------------------------------------------------------------------
// Converts HSV beats into 8-bit red, green and blue compare values. A beat
// passes four register stages (floor/amplitude, ramps and section mapping,
// dim scaling, power scaling) in that order, and out_valid_o is driven by
// the last of them. Each stage holds one multiplier level. Throughput is
// one beat per cycle while the output is not stalled, and a stall on the
// output backs up through the stages without loss. The power limit
// register resets to 32 and should only be written while the pipeline is
// empty.
module hsv_to_rgb_dimmed_core import hsvd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ChanW-1:0] hue_i,
  input  logic [ChanW-1:0] saturation_i,
  input  logic [ChanW-1:0] value_level_i,
  input  logic [ChanW-1:0] dim_level_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o,
  input  logic             cfg_we_i,
  input  logic [ChanW-1:0] cfg_wdata_i
);

  logic [ChanW-1:0] power_limit_val_q;
  logic             mid_valid;
  logic             mid_ready;
  rgb_t             mid_rgb;
  logic [ChanW-1:0] mid_dim;
  rgb_t             out_rgb;

  // power limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_limit_val_q <= PowerLimitReset;
    end else if (cfg_we_i) begin
      power_limit_val_q <= cfg_wdata_i;
    end
  end

  // color stages
  hsvd_color u_color (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .hue_i         (hue_i),
    .saturation_i  (saturation_i),
    .value_level_i (value_level_i),
    .dim_level_i   (dim_level_i),
    .out_valid_o   (mid_valid),
    .out_ready_i   (mid_ready),
    .rgb_o         (mid_rgb),
    .dim_o         (mid_dim)
  );

  // scaling stages
  hsvd_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (mid_valid),
    .in_ready_o    (mid_ready),
    .rgb_i         (mid_rgb),
    .dim_i         (mid_dim),
    .power_limit_i (power_limit_val_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .rgb_o         (out_rgb)
  );

  assign red_o   = out_rgb.red;
  assign green_o = out_rgb.green;
  assign blue_o  = out_rgb.blue;

`ifndef SYNTHESIS
  // back pressure only comes from a stalled, full output
  a_ready_low_means_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without an output stall");

  // an unstalled beat is offered at the output after passing every stage
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_valid_i && in_ready_o, 4) && $past(rst_ni, 4) && $past(rst_ni, 3) &&
     $past(rst_ni, 2) && $past(rst_ni, 1) && $past(out_ready_i, 3) &&
     $past(out_ready_i, 2) && $past(out_ready_i, 1)) |-> out_valid_o)
    else $error("beat did not reach the output in four cycles");

  // a fresh write is visible in the register on the next cycle
  a_cfg_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (power_limit_val_q == $past(cfg_wdata_i)))
    else $error("power limit write lost");
`endif

endmodule

FILE: test/tb_hsv_to_rgb_dimmed_core.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_dimmed_core
// Self-checking bench for the dimmed HSV to RGB converter.
// ----------------------------------------------------------------------------
// Every input beat is run through a local color model at the moment it is
// accepted. The model covers the saturation floor, the hue ramps, the
// section mapping, the dim scaling and the power scaling. The predicted
// triplet is queued, and each output beat is checked against the oldest
// entry. Directed beats hit the hue section edges and the field extremes.
// Random beats then run under several power limits, with random gaps and
// stalls on both sides and some stretches at full rate.
module tb_hsv_to_rgb_dimmed_core;
  import hsvd_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ReportMax   = 10;

  // clock, reset and ports
  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  logic [ChanW-1:0] hue         = '0;
  logic [ChanW-1:0] saturation  = '0;
  logic [ChanW-1:0] value_level = '0;
  logic [ChanW-1:0] dim_level   = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  logic             cfg_we      = 1'b0;
  logic [ChanW-1:0] cfg_wdata   = '0;

  // local copy of the power limit register
  logic [ChanW-1:0] limit_shadow = PowerLimitReset;
  rgb_t             expected_rgb_q[$];
  int unsigned      fault_cnt    = 0;
  int unsigned      idle_cycles  = 0;
  int unsigned      stall_left   = 0;
  bit               calm         = 1'b0;

  hsv_to_rgb_dimmed_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .hue_i         (hue),
    .saturation_i  (saturation),
    .value_level_i (value_level),
    .dim_level_i   (dim_level),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .red_o         (red),
    .green_o       (green),
    .blue_o        (blue),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  always #4 clk = ~clk;

  // truncating fractional scale, s over 256
  function automatic logic [ChanW-1:0] attenuate(input logic [ChanW-1:0] x,
                                                 input logic [ChanW-1:0] s);
    logic [2*ChanW-1:0] prod;
    prod = x * s;
    return prod[2*ChanW-1:ChanW];
  endfunction

  // expected output triplet for one beat
  function automatic rgb_t predict_rgb(input logic [ChanW-1:0] h, s, v, d, pl);
    logic [2*ChanW-1:0] floor_prod;
    logic [ChanW-1:0]   floor_lvl;
    logic [ChanW-1:0]   amp;
    logic [OffsetW-1:0] offset;
    logic [13:0]        up_prod;
    logic [13:0]        down_prod;
    logic [ChanW-1:0]   rise;
    logic [ChanW-1:0]   fall;
    rgb_t               raw;
    rgb_t               res;
    floor_prod = v * (8'hFF - s);
    floor_lvl  = floor_prod[2*ChanW-1:ChanW];
    amp        = v - floor_lvl;
    offset     = h[OffsetW-1:0];
    up_prod    = offset * amp;
    down_prod  = (6'd63 - offset) * amp;
    rise       = floor_lvl + up_prod[13:6];
    fall       = floor_lvl + down_prod[13:6];
    // top hue code maps like section 2
    case (h[ChanW-1:OffsetW])
      SECT_0: raw = '{red: fall, green: rise, blue: floor_lvl};
      SECT_1: raw = '{red: floor_lvl, green: fall, blue: rise};
      default: raw = '{red: rise, green: floor_lvl, blue: fall};
    endcase
    res.red   = attenuate(attenuate(raw.red, d), pl);
    res.green = attenuate(attenuate(raw.green, d), pl);
    res.blue  = attenuate(attenuate(raw.blue, d), pl);
    return res;
  endfunction

  // random byte with extra weight on the extremes
  function automatic logic [ChanW-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return ChanW'($urandom_range(0, 255));
  endfunction

  // idle length between beats: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one beat, predict on acceptance
  task automatic send_pixel(input logic [ChanW-1:0] h, s, v, d);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    hue         <= h;
    saturation  <= s;
    value_level <= v;
    dim_level   <= d;
    do @(posedge clk); while (!in_ready);
    expected_rgb_q.push_back(predict_rgb(h, s, v, d, limit_shadow));
  endtask

  task automatic send_random_pixel();
    send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
  endtask

  // hold off input until every result is out, then let the pipe settle
  task automatic wait_pipeline_empty();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rgb_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_power_limit(input logic [ChanW-1:0] lim);
    wait_pipeline_empty();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(negedge clk);
    cfg_we       <= 1'b0;
    limit_shadow  = lim;
  endtask

  // reset value of the power limit
  task automatic test_reset_limit();
    send_pixel(8'd0, 8'd0, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd160, 8'd77, 8'd201, 8'd180);
  endtask

  // section edges and field extremes at full rate
  task automatic test_directed();
    calm = 1'b1;
    set_power_limit(8'd255);
    send_pixel(8'd0, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd63, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd64, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd127, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd191, 8'd255, 8'd255, 8'd255);
    // hue above 191 still uses the section 2 mapping
    send_pixel(8'd192, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd255, 8'd255);
    send_pixel(8'd90, 8'd255, 8'd0, 8'd255);
    send_pixel(8'd40, 8'd255, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd100, 8'd128, 8'd200, 8'd128);
    send_pixel(8'd200, 8'd1, 8'd254, 8'd1);
    send_pixel(8'd32, 8'd254, 8'd1, 8'd254);
    send_pixel(8'd170, 8'd85, 8'd170, 8'd85);
    calm = 1'b0;
  endtask

  // extreme, middle and one random power limit
  task automatic test_power_limits();
    logic [ChanW-1:0] limits[5];
    limits = '{8'd0, 8'd1, 8'd128, 8'd255, ChanW'($urandom_range(0, 255))};
    foreach (limits[i]) begin
      set_power_limit(limits[i]);
      repeat (20) send_random_pixel();
    end
  endtask

  // long random run, limit changes between phases, some full rate stretches
  task automatic test_random_stream();
    for (int i = 0; i < 1000; i++) begin
      if (i % 250 == 0)
        set_power_limit(($urandom_range(0, 3) == 0) ? 8'd255 : pick_byte());
      calm = (i % 200 >= 100) && (i % 200 < 140);
      send_random_pixel();
    end
    calm = 1'b0;
  endtask

  // output backpressure
  always @(negedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 75) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                 : $urandom_range(10, 40);
    end
  end

  task automatic report_mismatch(input string field, input logic [ChanW-1:0] exp_v,
                                 input logic [ChanW-1:0] act_v);
    fault_cnt++;
    if (fault_cnt <= ReportMax)
      $display("mismatch on %s: expected %0d, got %0d", field, exp_v, act_v);
  endtask

  // compare each output beat with the oldest prediction
  always @(posedge clk) begin
    rgb_t exp_rgb;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rgb_q.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= ReportMax)
          $display("unexpected output beat: %0d %0d %0d", red, green, blue);
      end else begin
        exp_rgb = expected_rgb_q.pop_front();
        if (red !== exp_rgb.red) report_mismatch("red", exp_rgb.red, red);
        if (green !== exp_rgb.green) report_mismatch("green", exp_rgb.green, green);
        if (blue !== exp_rgb.blue) report_mismatch("blue", exp_rgb.blue, blue);
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb_hsv_to_rgb_dimmed_core: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_limit();
    test_directed();
    test_power_limits();
    test_random_stream();
    wait_pipeline_empty();
    if (fault_cnt == 0) begin
      $display("tb_hsv_to_rgb_dimmed_core: PASS");
    end else begin
      $display("tb_hsv_to_rgb_dimmed_core: FAIL");
    end
    $finish;
  end

endmodule
